// ===== rtl/dpra_pkg.sv =====
// Shared types and constants for the debounced pulse-rate averager.
// No dependencies; every other file of the block but dpra_if imports this package.
`timescale 1ns / 1ps

package dpra_pkg;

  // Ring depth default and the depth of the front-to-back queue
  localparam int unsigned RING_DEPTH_DEF = 5;
  localparam int unsigned Q_DEPTH        = 2;
  localparam int unsigned Q_PW           = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW           = $clog2(Q_DEPTH + 1);

  // Configuration port geometry
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 24;

  // Register indexes
  typedef enum logic [CFG_IW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_WINDOW   = 2'd1,
    REG_FACTOR   = 2'd2
  } reg_idx_t;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_RST = 16'd1;
  localparam logic [23:0] WINDOW_RST   = 24'd60000;
  localparam logic [15:0] FACTOR_RST   = 16'd354;

  // Saturation limits of the tick counters
  localparam logic [15:0] CNT16_MAX = 16'hFFFF;
  localparam logic [23:0] CNT24_MAX = 24'hFF_FFFF;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [23:0] window_ticks;
    logic [15:0] dose_factor;
  } cfg_t;

  // One classified tick as handed from the front to the back
  typedef struct packed {
    logic [15:0] window_count;
    logic [23:0] window_elapsed;
    logic        window_closed;
    logic [31:0] dose;
  } rec_t;

endpackage

// ===== rtl/dpra_if.sv =====
// Channel interfaces of the pulse-rate averager: tick input and result output.
// Depends on nothing; used by the front, the back and the top level.
`timescale 1ns / 1ps

interface dpra_in_if;
  logic valid;
  logic ready;
  logic line_active;

  modport source (output valid, output line_active, input ready);
  modport sink   (input valid, input line_active, output ready);
endinterface

interface dpra_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] window_count;
  logic [31:0] average_dose;
  logic [2:0]  filled_entries;
  logic [2:0]  ring_position;
  logic [23:0] window_elapsed;
  logic        window_closed;

  modport source (
    output valid, output window_count, output average_dose, output filled_entries,
    output ring_position, output window_elapsed, output window_closed, input ready
  );
  modport sink (
    input valid, input window_count, input average_dose, input filled_entries,
    input ring_position, input window_elapsed, input window_closed, output ready
  );
endinterface

// ===== rtl/dpra_front.sv =====
// Front of the averager: debounce, pulse count and window timing per tick.
// Depends on dpra_pkg and dpra_in_if; pushes one record per tick into the queue.
`timescale 1ns / 1ps

module dpra_front
  import dpra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  dpra_in_if.sink     ticks,
  output logic        push_valid,
  input  logic        push_ready,
  output rec_t        push_data
);

  logic [15:0] since_last;
  logic [23:0] window_timer;
  logic [15:0] pulse_count;

  logic [15:0] since_inc;
  logic [23:0] timer_inc;
  logic [15:0] count_next;
  logic [15:0] since_next;
  logic        hit;
  logic        closed;
  logic        fire;

  // Advance both timers, then test for a counted pulse and a closed window
  always_comb begin
    since_inc  = (since_last == CNT16_MAX) ? since_last : since_last + 16'd1;
    timer_inc  = (window_timer == CNT24_MAX) ? window_timer : window_timer + 24'd1;
    hit        = ticks.line_active && (since_inc >= cfg.debounce_ticks);
    count_next = pulse_count;
    since_next = since_inc;
    if (hit) begin
      count_next = (pulse_count == CNT16_MAX) ? pulse_count : pulse_count + 16'd1;
      since_next = '0;
    end
    closed = (timer_inc >= cfg.window_ticks);
  end

  // Build the record; the product is only used on a closing tick
  always_comb begin
    push_data.window_count   = closed ? 16'd0 : count_next;
    push_data.window_elapsed = closed ? 24'd0 : timer_inc;
    push_data.window_closed  = closed;
    push_data.dose           = 32'(count_next) * 32'(cfg.dose_factor);
  end

  assign ticks.ready = push_ready;
  assign fire        = ticks.valid && push_ready;
  assign push_valid  = ticks.valid;

  // Update tick state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      since_last   <= '0;
      window_timer <= '0;
      pulse_count  <= '0;
    end else if (fire) begin
      since_last   <= since_next;
      window_timer <= closed ? 24'd0 : timer_inc;
      pulse_count  <= closed ? 16'd0 : count_next;
    end
  end

endmodule

// ===== rtl/dpra_queue.sv =====
// Short FIFO between the front and the back of the averager.
// Depends on dpra_pkg for the record type and the depth.
`timescale 1ns / 1ps

module dpra_queue
  import dpra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  rec_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output rec_t pop_data
);

  rec_t            slots [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr;
  logic [Q_PW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != Q_CW'(Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed records
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dpra_back.sv =====
// Back of the averager: ring of window results, their sum and the mean.
// Depends on dpra_pkg and dpra_out_if; pops records from dpra_queue.
`timescale 1ns / 1ps

module dpra_back
  import dpra_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  rec_t        pop_data,
  dpra_out_if.source  results
);

  localparam int unsigned IW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW  = 32 + CW;
  localparam int unsigned DCW = $clog2(SW + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } st_t;

  st_t            state;
  logic [IW-1:0]  ring_idx;
  logic [CW-1:0]  fill_cnt;
  logic [31:0]    mean;
  logic [CW-1:0]  rd_cnt;
  logic           rd_pend;
  logic [SW-1:0]  acc;
  logic [CW-1:0]  rem;
  logic [DCW-1:0] dcnt;
  logic [31:0]    rdata;
  logic [31:0]    ring [RING_DEPTH];

  logic           out_valid;
  logic [15:0]    out_count;
  logic [31:0]    out_dose;
  logic [CW-1:0]  out_fill;
  logic [IW-1:0]  out_pos;
  logic [23:0]    out_elapsed;
  logic           out_closed;

  logic           take;
  logic           out_load;
  logic           mem_we;
  logic           rd_issue;
  logic [IW-1:0]  idx_next;
  logic [CW-1:0]  fill_next;
  logic [CW:0]    trial;
  logic [CW:0]    trial_sub;
  logic [CW+2:0]  fill_ext;
  logic [IW+2:0]  pos_ext;

  // Pop only when idle and the output register is free or being drained
  assign pop_ready = (state == ST_IDLE) && (!out_valid || results.ready);
  assign take      = pop_valid && pop_ready;
  assign out_load  = (take && !pop_data.window_closed) || (state == ST_OUT);
  assign mem_we    = take && pop_data.window_closed;
  assign rd_issue  = (state == ST_SUM) && (rd_cnt < fill_cnt);
  assign idx_next  = (ring_idx == IW'(RING_DEPTH - 1)) ? '0 : ring_idx + 1'b1;
  assign fill_next = (fill_cnt == CW'(RING_DEPTH)) ? fill_cnt : fill_cnt + 1'b1;
  assign trial     = {rem, acc[SW-1]};
  assign trial_sub = trial - {1'b0, fill_cnt};

  // Ring memory: write the new window result, read one entry per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[ring_idx] <= pop_data.dose;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rdata <= ring[rd_cnt[IW-1:0]];
    end
  end

  // Sequencer: on a closing record sum the filled entries, then divide one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ring_idx  <= '0;
      fill_cnt  <= '0;
      mean      <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
      rd_cnt    <= '0;
      dcnt      <= '0;
    end else begin
      // Load the output register on a new result, drop it once taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (pop_data.window_closed) begin
              ring_idx <= idx_next;
              fill_cnt <= fill_next;
              rd_cnt   <= '0;
              rd_pend  <= 1'b0;
              acc      <= '0;
              state    <= ST_SUM;
            end else begin
              out_count   <= pop_data.window_count;
              out_elapsed <= pop_data.window_elapsed;
              out_closed  <= 1'b0;
              out_dose    <= mean;
              out_fill    <= fill_cnt;
              out_pos     <= ring_idx;
            end
          end
        end
        ST_SUM: begin
          rd_pend <= rd_issue;
          if (rd_issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (rd_pend) begin
            acc <= acc + SW'(rdata);
          end
          if (!rd_issue && !rd_pend) begin
            rem   <= '0;
            dcnt  <= DCW'(SW);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!trial_sub[CW]) begin
            rem <= trial_sub[CW-1:0];
            acc <= {acc[SW-2:0], 1'b1};
          end else begin
            rem <= trial[CW-1:0];
            acc <= {acc[SW-2:0], 1'b0};
          end
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCW'(1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          mean        <= acc[31:0];
          out_count   <= '0;
          out_elapsed <= '0;
          out_closed  <= 1'b1;
          out_dose    <= acc[31:0];
          out_fill    <= fill_cnt;
          out_pos     <= ring_idx;
          state       <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Drive the result channel from the output register
  assign fill_ext = (CW+3)'(out_fill);
  assign pos_ext  = (IW+3)'(out_pos);

  assign results.valid          = out_valid;
  assign results.window_count   = out_count;
  assign results.average_dose   = out_dose;
  assign results.filled_entries = fill_ext[2:0];
  assign results.ring_position  = pos_ext[2:0];
  assign results.window_elapsed = out_elapsed;
  assign results.window_closed  = out_closed;

  // Checks on ring bookkeeping and the sequencer
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_cnt <= CW'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ring_idx < IW'(RING_DEPTH) || RING_DEPTH == (1 << IW))
    else $error("ring index beyond ring depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (fill_cnt != '0))
    else $error("divide with empty ring");

  a_close_starts_sum: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> (state == ST_SUM))
    else $error("closing record did not start the sum");

endmodule

// ===== rtl/debounced_pulse_rate_averager_unit.sv =====
// Top level of the debounced pulse-rate averager: config registers, front,
// queue and back. Depends on dpra_pkg, dpra_if, dpra_front, dpra_queue, dpra_back.
//
//   channel   dir   handshake             payload
//   ticks     in    valid/ready           line_active
//   results   out   valid/ready           window_count, average_dose, filled_entries,
//                                         ring_position, window_elapsed, window_closed
//   cfg       in    cfg_we (no wait)      cfg_index, cfg_wdata
//
// The back passes a tick that does not close a window straight to the output register;
// the front takes one tick per cycle while the two-entry queue has room.
// A closing tick holds the back from its pop to the next pop: the back reads the filled
// ring entries into the sum, divides it by the fill count a quotient bit at a time,
// then loads the output register.
// Synchronous reset clears all counters, the queue and the mean; ring entries are
// not cleared and are read only after being written.
// Either channel may stall; the queue and the output register keep them apart.
`timescale 1ns / 1ps

module debounced_pulse_rate_averager_unit
  import dpra_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  dpra_in_if.sink           ticks,
  dpra_out_if.source        results,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t cfg;
  logic push_valid;
  logic push_ready;
  rec_t push_data;
  logic pop_valid;
  logic pop_ready;
  rec_t pop_data;

  // Configuration registers; an unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks <= DEBOUNCE_RST;
      cfg.window_ticks   <= WINDOW_RST;
      cfg.dose_factor    <= FACTOR_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEBOUNCE: cfg.debounce_ticks <= cfg_wdata[15:0];
        REG_WINDOW:   cfg.window_ticks   <= cfg_wdata[23:0];
        REG_FACTOR:   cfg.dose_factor    <= cfg_wdata[15:0];
        default:      ;
      endcase
    end
  end

  dpra_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ticks      (ticks),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  dpra_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dpra_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .results   (results)
  );

endmodule

// ===== tb/debounced_pulse_rate_averager_unit_tb.sv =====
// Self-checking testbench for debounced_pulse_rate_averager_unit: directed table, then random
// phases with random stalls on both channels. Depends on dpra_pkg, dpra_if and the RTL.
`timescale 1ns / 1ps

module debounced_pulse_rate_averager_unit_tb;
  import dpra_pkg::*;

  localparam int unsigned RING_N = RING_DEPTH_DEF;
  // Index past the last register; writes to it must change nothing
  localparam logic [CFG_IW-1:0] REG_UNUSED = 2'd3;
  localparam int DIR_ROWS = 32;

  typedef struct packed {
    logic [15:0] window_count;
    logic [31:0] average_dose;
    logic [2:0]  filled_entries;
    logic [2:0]  ring_position;
    logic [23:0] window_elapsed;
    logic        window_closed;
  } dose_result_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic              line_level;
    logic [CFG_IW-1:0] reg_sel;
    logic [CFG_DW-1:0] reg_data;
    logic              typed;
    dose_result_t      want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = REG_DEBOUNCE;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  dpra_in_if  tick_ch ();
  dpra_out_if result_ch ();

  debounced_pulse_rate_averager_unit dut (
    .clk       (clk),
    .rst       (rst),
    .ticks     (tick_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Shadow of the block: configuration and counting state
  logic [15:0] c_debounce = DEBOUNCE_RST;
  logic [23:0] c_window   = WINDOW_RST;
  logic [15:0] c_factor   = FACTOR_RST;
  logic [15:0] p_pulses   = '0;
  logic [15:0] p_since    = '0;
  logic [23:0] p_timer    = '0;
  logic [31:0] p_ring [RING_N];
  logic [2:0]  p_slot     = '0;
  logic [2:0]  p_fill     = '0;
  logic [31:0] p_mean     = '0;

  dose_result_t dose_due[$];
  int           mismatch_count = 0;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  dir_row_t     dir_rows [DIR_ROWS];

  // Advance the shadow by one tick and return the result it must produce
  function automatic dose_result_t advance_dosimeter(input logic level);
    dose_result_t r;
    logic [63:0]  sum;
    logic [2:0]   slot;
    int           k;
    r.window_closed = 1'b0;
    if (p_since != CNT16_MAX) p_since = p_since + 16'd1;
    if (p_timer != CNT24_MAX) p_timer = p_timer + 24'd1;
    if (level && p_since >= c_debounce) begin
      if (p_pulses != CNT16_MAX) p_pulses = p_pulses + 16'd1;
      p_since = '0;
    end
    if (p_timer >= c_window) begin
      slot = (p_slot >= RING_N) ? 3'd0 : p_slot;
      p_ring[slot] = 32'(p_pulses) * 32'(c_factor);
      if (p_fill < RING_N) p_fill = p_fill + 3'd1;
      sum = '0;
      for (k = 0; k < int'(p_fill); k++) sum += 64'(p_ring[k]);
      p_mean = 32'(sum / 64'(p_fill));
      p_slot = (int'(slot) + 1 >= RING_N) ? 3'd0 : slot + 3'd1;
      p_pulses = '0;
      p_timer = '0;
      r.window_closed = 1'b1;
    end
    r.window_count   = p_pulses;
    r.average_dose   = p_mean;
    r.filled_entries = p_fill;
    r.ring_position  = p_slot;
    r.window_elapsed = p_timer;
    return r;
  endfunction

  // Mirror a register write in the shadow; unknown indexes are dropped
  function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    case (idx)
      REG_DEBOUNCE: c_debounce = data[15:0];
      REG_WINDOW:   c_window   = data;
      REG_FACTOR:   c_factor   = data[15:0];
      default: ;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one tick after a random gap; queue its expected result once accepted
  task automatic send_tick(input logic level, input logic typed, input dose_result_t want);
    int           gap;
    dose_result_t pred;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.line_active <= level;
    do @(posedge clk); while (!tick_ch.ready);
    pred = advance_dosimeter(level);
    dose_due.push_back(typed ? want : pred);
  endtask

  task automatic wait_drain();
    while (dose_due.size() != 0) @(posedge clk);
  endtask

  // Result checker: compare each accepted transaction with the oldest expectation
  always @(posedge clk) begin
    dose_result_t exp_r;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (dose_due.size() == 0) begin
        $error("unexpected result transaction: nothing queued");
        mismatch_count++;
      end else begin
        exp_r = dose_due.pop_front();
        if (result_ch.window_count !== exp_r.window_count) begin
          $error("window_count: expected %0d, got %0d", exp_r.window_count,
                 result_ch.window_count);
          mismatch_count++;
        end
        if (result_ch.average_dose !== exp_r.average_dose) begin
          $error("average_dose: expected %0d, got %0d", exp_r.average_dose,
                 result_ch.average_dose);
          mismatch_count++;
        end
        if (result_ch.filled_entries !== exp_r.filled_entries) begin
          $error("filled_entries: expected %0d, got %0d", exp_r.filled_entries,
                 result_ch.filled_entries);
          mismatch_count++;
        end
        if (result_ch.ring_position !== exp_r.ring_position) begin
          $error("ring_position: expected %0d, got %0d", exp_r.ring_position,
                 result_ch.ring_position);
          mismatch_count++;
        end
        if (result_ch.window_elapsed !== exp_r.window_elapsed) begin
          $error("window_elapsed: expected %0d, got %0d", exp_r.window_elapsed,
                 result_ch.window_elapsed);
          mismatch_count++;
        end
        if (result_ch.window_closed !== exp_r.window_closed) begin
          $error("window_closed: expected %0d, got %0d", exp_r.window_closed,
                 result_ch.window_closed);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: hold ready low for a random stall, then wait for a transaction
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 19) : 0;
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int          density;
    logic [15:0] deb;
    logic [23:0] win;
    logic [15:0] fac;

    tick_ch.valid       = 1'b0;
    tick_ch.line_active = 1'b0;

    // Directed table: reset values, zero and full-scale registers, ring wrap
    dir_rows = '{
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b1, '{16'd1, 32'd0, 3'd0, 3'd0, 24'd1, 1'b0}},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b1, '{16'd2, 32'd0, 3'd0, 3'd0, 24'd2, 1'b0}},
      '{ROW_TICK, 1'b0, REG_DEBOUNCE, 24'd0, 1'b1, '{16'd2, 32'd0, 3'd0, 3'd0, 24'd3, 1'b0}},
      '{ROW_CFG,  1'b0, REG_DEBOUNCE, 24'h00_0000, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_FACTOR,   24'hAB_FFFF, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_WINDOW,   24'h00_0000, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b1,
        '{16'd0, 32'd196605, 3'd1, 3'd1, 24'd0, 1'b1}},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b0, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_FACTOR,   24'h5A_0000, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_WINDOW,   24'h00_0001, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_WINDOW,   24'h00_0003, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_FACTOR,   24'h00_FFFF, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_DEBOUNCE, 24'hFF_FFFF, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_UNUSED,   24'h5A_5A5A, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_WINDOW,   24'hFF_FFFF, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_DEBOUNCE, 24'h00_0002, 1'b0, '0},
      '{ROW_CFG,  1'b0, REG_WINDOW,   24'h00_0004, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0},
      '{ROW_TICK, 1'b1, REG_DEBOUNCE, 24'd0, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the table; register rows wait for the block to go idle
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        tick_ch.valid <= 1'b0;
        wait_drain();
        write_reg(dir_rows[i].reg_sel, dir_rows[i].reg_data);
      end else begin
        send_tick(dir_rows[i].line_level, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: new settings, pulse density and idling mode per phase
    for (int ph = 0; ph < 10; ph++) begin
      tick_ch.valid <= 1'b0;
      wait_drain();
      case ($urandom_range(0, 5))
        0:       deb = 16'd0;
        1:       deb = 16'hFFFF;
        default: deb = 16'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 7))
        0:       win = 24'd0;
        1:       win = 24'hFF_FFFF;
        2:       win = 24'd1;
        default: win = 24'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       fac = 16'd0;
        1:       fac = 16'hFFFF;
        default: fac = 16'($urandom);
      endcase
      write_reg(REG_DEBOUNCE, {8'($urandom), deb});
      write_reg(REG_WINDOW, win);
      write_reg(REG_FACTOR, {8'($urandom), fac});
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 24'($urandom));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      density = $urandom_range(0, 100);
      for (int n = 0; n < 50; n++) begin
        // At random, hold off mid-phase until every result is back
        if (n == 25 && $urandom_range(0, 1) == 1) begin
          tick_ch.valid <= 1'b0;
          wait_drain();
        end
        send_tick($urandom_range(0, 99) < density, 1'b0, '0);
      end
    end

    tick_ch.valid <= 1'b0;
    wait_drain();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && dose_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
